FILE: hw/rtl/hwag_pkg.sv
// ----------------------------------------------------------------------------
// hwag_pkg
// Shared constants and types for the homography warp address generator.
// ----------------------------------------------------------------------------
package hwag_pkg;

    // Source image size and coefficient fraction bits.
    localparam int SRC_WIDTH  = 2048;
    localparam int SRC_HEIGHT = 2048;
    localparam int FRAC_BITS  = 32;

    // Field and datapath widths.
    localparam int COORD_W = 12;
    localparam int COEF_W  = 48;
    localparam int NUM_COEF = 8;
    localparam int PROD_W  = COEF_W + COORD_W + 1;
    localparam int SUM_W   = 63;
    localparam int QUOT_W  = COORD_W + 1;
    localparam int CMP_W   = SUM_W + QUOT_W;
    localparam int ADDR_W  = 6;

    // Register indexes.
    localparam logic [2:0] REG_COEF_00 = 3'd0;
    localparam logic [2:0] REG_COEF_01 = 3'd1;
    localparam logic [2:0] REG_COEF_02 = 3'd2;
    localparam logic [2:0] REG_COEF_10 = 3'd3;
    localparam logic [2:0] REG_COEF_11 = 3'd4;
    localparam logic [2:0] REG_COEF_12 = 3'd5;
    localparam logic [2:0] REG_COEF_20 = 3'd6;
    localparam logic [2:0] REG_COEF_21 = 3'd7;

    // Reset value of the diagonal coefficients, 1.0.
    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0]  SUM_ONE  = SUM_W'(64'd1 << FRAC_BITS);

    localparam logic [QUOT_W-1:0] LIM_X = QUOT_W'(SRC_WIDTH);
    localparam logic [QUOT_W-1:0] LIM_Y = QUOT_W'(SRC_HEIGHT);

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [SUM_W-1:0]         t_mag;
    typedef logic [QUOT_W-1:0]        t_quot;

endpackage

FILE: hw/rtl/homography_warp_address_gen.sv
// ----------------------------------------------------------------------------
// homography_warp_address_gen
// Maps each output pixel to its nearest source pixel through a homography.
// ----------------------------------------------------------------------------
// Usage: output coordinates arrive on the slave stream (tdata = out_x, out_y),
// one request per clock unless the receiver stalls. Each request yields exactly
// one result on the master stream: tdata = src_x, src_y and tuser = outside.
// Outside pixels carry zero coordinates and are filled with gray downstream.
// The pipeline takes one request every cycle while the output can take data:
// three stages form X, Y and W, a 13-stage restoring divider makes one quotient
// bit per stage for both axes, and a final stage bounds-checks into the output
// register. The eight coefficients are written over the APB port at byte
// address 8*i; the user must write them only while no request is in flight,
// and the block does not enforce this. Reset loads the identity mapping and
// empties the pipeline. When the receiver stalls, the whole pipeline holds and
// s_tready drops once the output register is full; nothing is lost.
module homography_warp_address_gen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hwag_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    // Slave stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [23:0]                 i_s_tdata,  // [11:0] out_x, [23:12] out_y
    // Master stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [23:0]                 o_m_tdata,  // [11:0] src_x, [23:12] src_y
    output logic                        o_m_tuser   // [0] outside
);

    localparam int NDIV = hwag_pkg::QUOT_W;

    // Coefficient registers.
    hwag_pkg::t_coef r_coef [hwag_pkg::NUM_COEF];

    assign pready = 1'b1;
    assign prdata = 64'(signed'(r_coef[paddr[5:3]]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hwag_pkg::NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
            r_coef[hwag_pkg::REG_COEF_00] <= hwag_pkg::COEF_ONE;
            r_coef[hwag_pkg::REG_COEF_11] <= hwag_pkg::COEF_ONE;
        end else if (psel && penable && pwrite && pready) begin
            r_coef[paddr[5:3]] <= pwdata[hwag_pkg::COEF_W-1:0];
        end
    end

    // Global advance: the pipeline moves when the output register can take data.
    logic w_adv;
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    // Valid bits for product, sum, magnitude and divider stages.
    logic r_v1, r_v2;
    logic r_vd [NDIV+1];

    // Stage 1: six products.
    logic signed [hwag_pkg::PROD_W-1:0] r_p [6];
    logic signed [hwag_pkg::COORD_W:0]  w_x, w_y;
    assign w_x = {1'b0, i_s_tdata[11:0]};
    assign w_y = {1'b0, i_s_tdata[23:12]};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p[0] <= r_coef[hwag_pkg::REG_COEF_00] * w_x;
            r_p[1] <= r_coef[hwag_pkg::REG_COEF_01] * w_y;
            r_p[2] <= r_coef[hwag_pkg::REG_COEF_10] * w_x;
            r_p[3] <= r_coef[hwag_pkg::REG_COEF_11] * w_y;
            r_p[4] <= r_coef[hwag_pkg::REG_COEF_20] * w_x;
            r_p[5] <= r_coef[hwag_pkg::REG_COEF_21] * w_y;
        end
    end

    // Stage 2: exact sums for X, Y and W.
    hwag_pkg::t_sum r_sx, r_sy, r_sw;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sx <= hwag_pkg::SUM_W'(r_p[0]) + hwag_pkg::SUM_W'(r_p[1])
                  + hwag_pkg::SUM_W'(r_coef[hwag_pkg::REG_COEF_02]);
            r_sy <= hwag_pkg::SUM_W'(r_p[2]) + hwag_pkg::SUM_W'(r_p[3])
                  + hwag_pkg::SUM_W'(r_coef[hwag_pkg::REG_COEF_12]);
            r_sw <= hwag_pkg::SUM_W'(r_p[4]) + hwag_pkg::SUM_W'(r_p[5])
                  + hwag_pkg::SUM_ONE;
        end
    end

    // Divider stages: index 0 holds magnitudes, index k holds k quotient bits.
    hwag_pkg::t_mag  r_rx [NDIV+1];
    hwag_pkg::t_mag  r_ry [NDIV+1];
    hwag_pkg::t_mag  r_dw [NDIV+1];
    hwag_pkg::t_quot r_qx [NDIV+1];
    hwag_pkg::t_quot r_qy [NDIV+1];
    logic            r_nx [NDIV+1];
    logic            r_ny [NDIV+1];
    logic            r_wz [NDIV+1];
    logic            r_ox [NDIV+1];
    logic            r_oy [NDIV+1];

    hwag_pkg::t_mag w_mx, w_my, w_mw;
    assign w_mx = r_sx[hwag_pkg::SUM_W-1] ? hwag_pkg::t_mag'(-r_sx) : hwag_pkg::t_mag'(r_sx);
    assign w_my = r_sy[hwag_pkg::SUM_W-1] ? hwag_pkg::t_mag'(-r_sy) : hwag_pkg::t_mag'(r_sy);
    assign w_mw = r_sw[hwag_pkg::SUM_W-1] ? hwag_pkg::t_mag'(-r_sw) : hwag_pkg::t_mag'(r_sw);

    logic [hwag_pkg::CMP_W-1:0] w_top;
    assign w_top = {w_mw, {NDIV{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // Magnitudes, signs and quotient overflow past the quotient width.
            r_rx[0] <= w_mx;
            r_ry[0] <= w_my;
            r_dw[0] <= w_mw;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_nx[0] <= r_sx[hwag_pkg::SUM_W-1] ^ r_sw[hwag_pkg::SUM_W-1];
            r_ny[0] <= r_sy[hwag_pkg::SUM_W-1] ^ r_sw[hwag_pkg::SUM_W-1];
            r_wz[0] <= (r_sw == '0);
            r_ox[0] <= (hwag_pkg::CMP_W'(w_mx) >= w_top);
            r_oy[0] <= (hwag_pkg::CMP_W'(w_my) >= w_top);
            // One restoring step per stage, most significant bit first.
            for (int j = 1; j <= NDIV; j++) begin
                logic [hwag_pkg::CMP_W-1:0] w_dsh;
                w_dsh = hwag_pkg::CMP_W'(r_dw[j-1]) << (NDIV - j);
                r_dw[j] <= r_dw[j-1];
                r_nx[j] <= r_nx[j-1];
                r_ny[j] <= r_ny[j-1];
                r_wz[j] <= r_wz[j-1];
                r_ox[j] <= r_ox[j-1];
                r_oy[j] <= r_oy[j-1];
                if (hwag_pkg::CMP_W'(r_rx[j-1]) >= w_dsh) begin
                    r_rx[j] <= r_rx[j-1] - hwag_pkg::SUM_W'(w_dsh);
                    r_qx[j] <= r_qx[j-1] | hwag_pkg::QUOT_W'(1 << (NDIV - j));
                end else begin
                    r_rx[j] <= r_rx[j-1];
                    r_qx[j] <= r_qx[j-1];
                end
                if (hwag_pkg::CMP_W'(r_ry[j-1]) >= w_dsh) begin
                    r_ry[j] <= r_ry[j-1] - hwag_pkg::SUM_W'(w_dsh);
                    r_qy[j] <= r_qy[j-1] | hwag_pkg::QUOT_W'(1 << (NDIV - j));
                end else begin
                    r_ry[j] <= r_ry[j-1];
                    r_qy[j] <= r_qy[j-1];
                end
            end
        end
    end

    // Bounds check of both quotients.
    logic w_okx, w_oky, w_ok;
    hwag_pkg::t_quot w_qx, w_qy;
    assign w_qx  = r_qx[NDIV];
    assign w_qy  = r_qy[NDIV];
    assign w_okx = !r_ox[NDIV] && ((w_qx == '0) || (!r_nx[NDIV] && w_qx < hwag_pkg::LIM_X));
    assign w_oky = !r_oy[NDIV] && ((w_qy == '0) || (!r_ny[NDIV] && w_qy < hwag_pkg::LIM_Y));
    assign w_ok  = !r_wz[NDIV] && w_okx && w_oky;

    // Valid bits and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            o_m_tvalid <= 1'b0;
            for (int j = 0; j <= NDIV; j++) begin
                r_vd[j] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v1       <= i_s_tvalid;
            r_v2       <= r_v1;
            r_vd[0]    <= r_v2;
            for (int j = 1; j <= NDIV; j++) begin
                r_vd[j] <= r_vd[j-1];
            end
            o_m_tvalid <= r_vd[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_m_tdata[11:0]  <= w_ok ? w_qx[11:0] : 12'd0;
            o_m_tdata[23:12] <= w_ok ? w_qy[11:0] : 12'd0;
            o_m_tuser        <= !w_ok;
        end
    end

    // An outside result carries zero coordinates.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == 24'd0)
        else $error("outside result with nonzero coordinates");

    // An inside result lies within the source image.
    a_inside_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |->
            {1'b0, o_m_tdata[11:0]} < hwag_pkg::LIM_X
            && {1'b0, o_m_tdata[23:12]} < hwag_pkg::LIM_Y)
        else $error("inside result beyond source size");

    // A stalled result stays valid and is not overwritten.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result was overwritten");

endmodule

FILE: tb/homography_warp_address_gen_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homography_warp_address_gen_test
// Drives output pixel coordinates through the warp address generator under
// several coefficient sets and handshake patterns, predicts each source
// address and outside flag, and checks every result in order.
// ----------------------------------------------------------------------------
module homography_warp_address_gen_test;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 40;
    localparam int  HOLD_OFF_LEN   = 200;
    localparam logic [hwag_pkg::ADDR_W-1:0] REG_STRIDE = 6'd8;

    typedef struct packed {
        logic [hwag_pkg::COORD_W-1:0] py;
        logic [hwag_pkg::COORD_W-1:0] px;
    } t_pixel;

    typedef struct packed {
        logic                         outside;
        logic [hwag_pkg::COORD_W-1:0] sy;
        logic [hwag_pkg::COORD_W-1:0] sx;
    } t_addr;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [hwag_pkg::ADDR_W-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic o_m_tuser;

    homography_warp_address_gen dut (.*);

    always #6 i_clk = ~i_clk;

    // Testbench copy of the coefficient registers.
    hwag_pkg::t_coef matrix [hwag_pkg::NUM_COEF];

    t_pixel pixel_queue [$];
    t_addr  addr_queue [$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_off_cycles = 0;
    logic   hold_off_want = 1'b0;
    logic   hold_off_done = 1'b0;
    int     mismatches = 0;
    int     idle_cycles = 0;
    logic   accepted_in = 1'b0;

    // Truncated quotient checked against a limit; den is nonzero.
    function automatic logic map_axis(input logic signed [63:0] num,
                                      input logic signed [63:0] den,
                                      input int lim,
                                      output logic [hwag_pkg::COORD_W-1:0] q_out);
        logic [63:0] q;
        logic [63:0] mn, md;
        mn = num[63] ? -num : num;
        md = den[63] ? -den : den;
        q = mn / md;
        q_out = '0;
        if (q == 0) return 1'b1;
        if ((num[63] != den[63]) || q >= 64'(lim)) return 1'b0;
        q_out = q[hwag_pkg::COORD_W-1:0];
        return 1'b1;
    endfunction

    function automatic t_addr warp_pixel(input t_pixel p);
        logic signed [63:0] x, y, nx, ny, nw;
        logic ok;
        t_addr r;
        x = {52'd0, p.px};
        y = {52'd0, p.py};
        nx = 64'(matrix[hwag_pkg::REG_COEF_00]) * x + 64'(matrix[hwag_pkg::REG_COEF_01]) * y
           + 64'(matrix[hwag_pkg::REG_COEF_02]);
        ny = 64'(matrix[hwag_pkg::REG_COEF_10]) * x + 64'(matrix[hwag_pkg::REG_COEF_11]) * y
           + 64'(matrix[hwag_pkg::REG_COEF_12]);
        nw = 64'(matrix[hwag_pkg::REG_COEF_20]) * x + 64'(matrix[hwag_pkg::REG_COEF_21]) * y
           + (64'sd1 <<< hwag_pkg::FRAC_BITS);
        r = '0;
        ok = 1'b0;
        if (nw != 0) begin
            ok = map_axis(nx, nw, hwag_pkg::SRC_WIDTH, r.sx);
            if (ok) ok = map_axis(ny, nw, hwag_pkg::SRC_HEIGHT, r.sy);
        end
        if (!ok) begin
            r.sx = '0;
            r.sy = '0;
        end
        r.outside = !ok;
        return r;
    endfunction

    // Driver: offers queued pixels, idling at random.
    always @(negedge i_clk) begin
        if (!i_s_tvalid || accepted_in) begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pixel_queue.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure and one long hold-off when asked for.
    always @(negedge i_clk) begin
        if (hold_off_want && !hold_off_done) begin
            hold_off_done   <= 1'b1;
            hold_off_cycles <= HOLD_OFF_LEN;
            i_m_tready      <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_m_tready      <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Acceptance flag and prediction at the rising edge.
    always @(posedge i_clk) begin
        accepted_in <= i_s_tvalid && o_s_tready;
        if (i_s_tvalid && o_s_tready) addr_queue.push_back(warp_pixel(t_pixel'(i_s_tdata)));
    end

    // Monitor: compares each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_addr got, want;
        if (o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser, o_m_tdata};
            if (addr_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = addr_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected x=%0d y=%0d out=%0b",
                                  " got x=%0d y=%0d out=%0b"},
                                 want.sx, want.sy, want.outside, got.sx, got.sy, got.outside);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_coef(input int idx, input hwag_pkg::t_coef val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= hwag_pkg::ADDR_W'(idx) * REG_STRIDE;
        pwdata <= {{16{val[hwag_pkg::COEF_W-1]}}, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        matrix[idx] = val;
    endtask

    task automatic wait_drained();
        while (pixel_queue.size() > 0 || i_s_tvalid || addr_queue.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic hwag_pkg::t_coef rand_coef(input int mode);
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        case (mode)
            0: return hwag_pkg::t_coef'(v);
            1: return hwag_pkg::t_coef'($signed(v[39:0]) >>> $urandom_range(20));
            default: return hwag_pkg::t_coef'($signed(v[30:0]) >>> $urandom_range(16));
        endcase
    endfunction

    function automatic t_pixel rand_pixel(input bit narrow);
        t_pixel p;
        p.px = narrow ? hwag_pkg::COORD_W'($urandom_range(63)) : hwag_pkg::COORD_W'($urandom);
        p.py = narrow ? hwag_pkg::COORD_W'($urandom_range(63)) : hwag_pkg::COORD_W'($urandom);
        return p;
    endfunction

    initial begin
        hwag_pkg::t_coef ident [hwag_pkg::NUM_COEF];
        int n;
        ident = '{hwag_pkg::COEF_ONE, 0, 0, 0, hwag_pkg::COEF_ONE, 0, 0, 0};
        matrix = ident;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: identity, field extremes and the bounds of the image.
        pixel_queue.push_back('{py: 12'd0, px: 12'd0});
        pixel_queue.push_back('{py: 12'hfff, px: 12'hfff});
        pixel_queue.push_back('{py: 12'd2047, px: 12'd2047});
        pixel_queue.push_back('{py: 12'd2048, px: 12'd5});
        pixel_queue.push_back('{py: 12'd7, px: 12'd2048});
        pixel_queue.push_back('{py: 12'haaa, px: 12'h555});
        wait_drained();

        // Zero denominator: W = 1 - x/4 vanishes at x = 4.
        write_coef(int'(hwag_pkg::REG_COEF_20),
                   -hwag_pkg::t_coef'(hwag_pkg::COEF_ONE >>> 2));
        for (int v = 2; v <= 6; v++) pixel_queue.push_back('{py: 12'd1, px: 12'(v)});
        // Small negative quotient and negative offsets.
        pixel_queue.push_back('{py: 12'd0, px: 12'd0});
        wait_drained();
        write_coef(int'(hwag_pkg::REG_COEF_20), '0);
        write_coef(int'(hwag_pkg::REG_COEF_02),
                   -hwag_pkg::t_coef'(hwag_pkg::COEF_ONE >>> 1));
        write_coef(int'(hwag_pkg::REG_COEF_12),
                   -hwag_pkg::t_coef'(3 * hwag_pkg::COEF_ONE));
        pixel_queue.push_back('{py: 12'd0, px: 12'd0});
        pixel_queue.push_back('{py: 12'd3, px: 12'd0});
        pixel_queue.push_back('{py: 12'd5, px: 12'd1});
        wait_drained();
        // Coefficient extremes.
        for (int k = 0; k < hwag_pkg::NUM_COEF; k++) write_coef(k, {1'b1, 47'd0});
        pixel_queue.push_back('{py: 12'hfff, px: 12'hfff});
        pixel_queue.push_back('{py: 12'd1, px: 12'd0});
        wait_drained();
        for (int k = 0; k < hwag_pkg::NUM_COEF; k++) write_coef(k, {1'b0, {47{1'b1}}});
        pixel_queue.push_back('{py: 12'hfff, px: 12'hfff});
        pixel_queue.push_back('{py: 12'd0, px: 12'd1});
        wait_drained();

        // Random phases with fresh coefficients and idling patterns.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int k = 0; k < hwag_pkg::NUM_COEF; k++) begin
                if (k == int'(hwag_pkg::REG_COEF_00) || k == int'(hwag_pkg::REG_COEF_11))
                    write_coef(k, hwag_pkg::COEF_ONE + rand_coef(2));
                else if (k >= int'(hwag_pkg::REG_COEF_20))
                    write_coef(k, ph == 0 ? '0 : rand_coef(2) >>> 6);
                else
                    write_coef(k, ph == 5 ? rand_coef(0) : rand_coef(ph % 2 ? 1 : 2));
            end
            n = 100;
            for (int i = 0; i < n; i++) pixel_queue.push_back(rand_pixel(i % 3 == 0));
            if (ph == 2) hold_off_want = 1'b1;
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/hwag_pkg.sv
hw/rtl/homography_warp_address_gen.sv
tb/homography_warp_address_gen_test.sv
